// ===== sv/fql_pkg.sv =====
// fql_pkg: shared types for the FIFO-queued lock.
// Holds the request and result item types, status codes and the
// command/status structs that join the controller and the datapath.
`timescale 1ns / 1ps

package fql_pkg;

  localparam int unsigned NumWaitersDef = 16;
  localparam int unsigned IdW           = 4;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_GRANTED     = 3'd0,
    STAT_QUEUED      = 3'd1,
    STAT_DUP         = 3'd2,
    STAT_HANDOFF     = 3'd3,
    STAT_RELEASED    = 3'd4,
    STAT_FREE_UNLOCK = 3'd5
  } status_e;

  typedef struct packed {
    logic           opcode;
    logic [IdW-1:0] waiter_id;
  } req_t;

  typedef struct packed {
    status_e        status;
    logic           woken_valid;
    logic [IdW-1:0] woken_id;
  } res_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_GRANT,
    ACT_ENQUEUE,
    ACT_IGNORE,
    ACT_HANDOFF,
    ACT_RELEASE,
    ACT_FREE_UNLOCK
  } action_e;

  typedef enum logic {
    CS_IDLE,
    CS_DECIDE
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;
    action_e action;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic unlock;
    logic held;
    logic empty;
    logic reject;
  } dp_stat_t;

endpackage

// ===== sv/fifo_queued_lock_core.sv =====
// fifo_queued_lock_core: top level of the FIFO-queued hardware lock.
// Depends on fql_pkg, fql_ctrl and fql_datapath.
//
// Usage:
//   Command channel: drive req_i (opcode, waiter_id) and raise start. The
//   item is taken at a rising edge where start is high and busy is low.
//   A lock request is granted when the lock is free, otherwise the waiter
//   id goes to the tail of a FIFO wait queue (ignored if already queued,
//   out of range or queue full). An unlock hands the lock to the oldest
//   waiter (woken_valid, woken_id) or frees it when nobody waits.
//   Result channel: done_o is high for exactly one cycle with res_o valid.
//   There is no backpressure; the receiver must take the item that cycle.
//   Timing: the item is decided in the cycle after it is taken and done_o
//   rises in the cycle after that. busy is high only in the decide cycle,
//   so a new item can be taken while done_o is up. The pace is set by
//   the registered read of the wait-slot memory at the queue head, which
//   must settle after each enqueue or head advance before the next
//   decision.
//   Reset (rst_ni low, async): lock free, queue empty, mask clear; the
//   slot memory is not cleared, only written slots are ever read.
`timescale 1ns / 1ps

module fifo_queued_lock_core
  import fql_pkg::*;
#(
  parameter int unsigned NUM_WAITERS = NumWaitersDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  req_t req_i,
  output logic busy,
  output logic done_o,
  output res_t res_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // controller: idle / decide sequencing and action selection
  fql_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (dp_cmd),
    .busy_o  (busy)
  );

  // datapath: lock flag, circular queue, queued mask, result register
  fql_datapath #(
    .NUM_WAITERS (NUM_WAITERS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (dp_cmd),
    .stat_o (dp_stat),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

// ===== sv/fql_ctrl.sv =====
// fql_ctrl: controller state machine of the FIFO-queued lock.
// Depends on fql_pkg; picks one datapath action per item from its status.
`timescale 1ns / 1ps

module fql_ctrl
  import fql_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.action = ACT_NONE;
    busy_o       = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_DECIDE;
        end
      end
      CS_DECIDE: begin
        busy_o  = 1'b1;
        state_d = CS_IDLE;
        priority if (!stat_i.unlock && !stat_i.held) begin
          cmd_o.action = ACT_GRANT;
        end else if (!stat_i.unlock && stat_i.reject) begin
          cmd_o.action = ACT_IGNORE;
        end else if (!stat_i.unlock) begin
          cmd_o.action = ACT_ENQUEUE;
        end else if (!stat_i.held) begin
          cmd_o.action = ACT_FREE_UNLOCK;
        end else if (!stat_i.empty) begin
          cmd_o.action = ACT_HANDOFF;
        end else begin
          cmd_o.action = ACT_RELEASE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/fql_datapath.sv =====
// fql_datapath: lock flag, circular wait queue, queued-id mask, result register.
// Depends on fql_pkg; driven by commands from fql_ctrl.
`timescale 1ns / 1ps

module fql_datapath
  import fql_pkg::*;
#(
  parameter int unsigned NUM_WAITERS = NumWaitersDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  req_t     req_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output logic     done_o,
  output res_t     res_o
);

  localparam int unsigned PtrW = $clog2(NUM_WAITERS);
  localparam int unsigned CntW = $clog2(NUM_WAITERS + 1);

  req_t                   req_q;
  logic                   held_q;
  logic [PtrW-1:0]        head_q;
  logic [CntW-1:0]        count_q;
  logic [NUM_WAITERS-1:0] mask_q;
  logic [IdW-1:0]         slot_rd_q;
  logic                   done_q;
  res_t                   res_q;

  logic [IdW-1:0]         slots [NUM_WAITERS];

  logic [PtrW+IdW-1:0]    req_wide, who_wide;
  logic                   req_in_range, who_in_range;
  logic [PtrW-1:0]        req_idx, who_idx;
  logic [PtrW:0]          tail_sum;
  logic [PtrW-1:0]        tail, head_nxt;
  logic                   full;

  // ids are 4 bits wide; widen so range checks and mask indexes work at any depth
  assign req_wide     = {{PtrW{1'b0}}, req_q.waiter_id};
  assign who_wide     = {{PtrW{1'b0}}, slot_rd_q};
  assign req_in_range = req_wide < (PtrW+IdW)'(NUM_WAITERS);
  assign who_in_range = who_wide < (PtrW+IdW)'(NUM_WAITERS);
  assign req_idx      = req_wide[PtrW-1:0];
  assign who_idx      = who_wide[PtrW-1:0];

  assign full = count_q >= CntW'(NUM_WAITERS);

  // count < NUM_WAITERS whenever we enqueue, so one conditional subtract wraps
  assign tail_sum = {1'b0, head_q} + (PtrW+1)'(count_q);
  assign tail     = (tail_sum >= (PtrW+1)'(NUM_WAITERS))
                  ? PtrW'(tail_sum - (PtrW+1)'(NUM_WAITERS))
                  : tail_sum[PtrW-1:0];
  assign head_nxt = (head_q == PtrW'(NUM_WAITERS - 1)) ? '0 : head_q + PtrW'(1);

  assign stat_o.unlock = (req_q.opcode == OP_UNLOCK);
  assign stat_o.held   = held_q;
  assign stat_o.empty  = (count_q == '0);
  assign stat_o.reject = !req_in_range || mask_q[req_idx] || full;

  // slot memory: one write port at the tail, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.action == ACT_ENQUEUE) begin
      slots[tail] <= req_q.waiter_id;
    end
    slot_rd_q <= slots[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= 1'b0;
      head_q  <= '0;
      count_q <= '0;
      mask_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (cmd_i.action != ACT_NONE);
      unique case (cmd_i.action)
        ACT_GRANT: begin
          held_q <= 1'b1;
        end
        ACT_ENQUEUE: begin
          mask_q[req_idx] <= 1'b1;
          count_q         <= count_q + CntW'(1);
        end
        ACT_HANDOFF: begin
          if (who_in_range) begin
            mask_q[who_idx] <= 1'b0;
          end
          head_q  <= head_nxt;
          count_q <= count_q - CntW'(1);
        end
        ACT_RELEASE: begin
          held_q <= 1'b0;
        end
        ACT_NONE, ACT_IGNORE, ACT_FREE_UNLOCK: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.action != ACT_NONE) begin
      res_q.woken_valid <= 1'b0;
      res_q.woken_id    <= '0;
      unique case (cmd_i.action)
        ACT_GRANT:       res_q.status <= STAT_GRANTED;
        ACT_ENQUEUE:     res_q.status <= STAT_QUEUED;
        ACT_IGNORE:      res_q.status <= STAT_DUP;
        ACT_HANDOFF: begin
          res_q.status      <= STAT_HANDOFF;
          res_q.woken_valid <= 1'b1;
          res_q.woken_id    <= slot_rd_q;
        end
        ACT_RELEASE:     res_q.status <= STAT_RELEASED;
        ACT_FREE_UNLOCK: res_q.status <= STAT_FREE_UNLOCK;
        default:         res_q.status <= STAT_DUP;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
